// ===== hw/rtl/pdr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the planar dead-reckoning core.
// Used by the CORDIC unit, the multiplier and the top level; depends on nothing.
package pdr_pkg;

	// Default CORDIC iteration count and the length of the arctangent table.
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 30;

	// Fixed-point constants: CORDIC start gain in Q1.30, radians to binary angle.
	localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sh26DD_3B6A;
	localparam logic signed [31:0] BAM_PER_RAD     = 32'sh28BE_60DC;

	// Field and state widths.
	localparam int ACC_IN_W = 16;
	localparam int VEL_W    = 32;
	localparam int POS_W    = 48;
	localparam int ANG_W    = 32;
	localparam int MUL_W    = 32;

	typedef logic signed [MUL_W-1:0]   mul_op_t;
	typedef logic signed [2*MUL_W-1:0] mul_prod_t;
	typedef logic signed [VEL_W-1:0]   vel_t;
	typedef logic signed [POS_W-1:0]   pos_t;
	typedef logic [ANG_W-1:0]          angle_t;

	// Handshake between the sequencer and the CORDIC unit.
	typedef struct packed {
		logic   start;
		angle_t angle;
	} cordic_req_t;

	// atan(2^-i) in binary-angle units, rounded to nearest.
	function automatic logic signed [31:0] atan_bam(input logic [4:0] idx);
		logic signed [31:0] v;
		unique case (idx)
			5'd0:    v = 32'sh2000_0000;
			5'd1:    v = 32'sh12E4_051E;
			5'd2:    v = 32'sh09FB_385B;
			5'd3:    v = 32'sh0511_11D4;
			5'd4:    v = 32'sh028B_0D43;
			5'd5:    v = 32'sh0145_D7E1;
			5'd6:    v = 32'sh00A2_F61E;
			5'd7:    v = 32'sh0051_7C55;
			5'd8:    v = 32'sh0028_BE53;
			5'd9:    v = 32'sh0014_5F2F;
			5'd10:   v = 32'sh000A_2F98;
			5'd11:   v = 32'sh0005_17CC;
			5'd12:   v = 32'sh0002_8BE6;
			5'd13:   v = 32'sh0001_45F3;
			5'd14:   v = 32'sh0000_A2FA;
			5'd15:   v = 32'sh0000_517D;
			5'd16:   v = 32'sh0000_28BE;
			5'd17:   v = 32'sh0000_145F;
			5'd18:   v = 32'sh0000_0A30;
			5'd19:   v = 32'sh0000_0518;
			5'd20:   v = 32'sh0000_028C;
			5'd21:   v = 32'sh0000_0146;
			5'd22:   v = 32'sh0000_00A3;
			5'd23:   v = 32'sh0000_0051;
			5'd24:   v = 32'sh0000_0029;
			5'd25:   v = 32'sh0000_0014;
			5'd26:   v = 32'sh0000_000A;
			5'd27:   v = 32'sh0000_0005;
			5'd28:   v = 32'sh0000_0003;
			5'd29:   v = 32'sh0000_0001;
			default: v = 32'sh0000_0000;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/pdr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for IMU sample words and pose result words.
// Depends on nothing; field widths follow the IMU sample and pose formats.
interface pdr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_fwd;
	logic signed [15:0] accel_side;
	logic signed [15:0] yaw_rate;
	logic [15:0]        elapsed;

	modport source (output valid, accel_fwd, accel_side, yaw_rate, elapsed, input ready);
	modport sink   (input valid, accel_fwd, accel_side, yaw_rate, elapsed, output ready);
endinterface

interface pdr_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic [31:0]        heading;

	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

// ===== hw/rtl/pdr_mul.sv =====
`timescale 1ns / 1ps
// Shared signed 32x32 multiplier with a registered product.
// Depends on pdr_pkg for operand and product types.
module pdr_mul (
	input  logic              clk,
	input  pdr_pkg::mul_op_t  a,
	input  pdr_pkg::mul_op_t  b,
	output pdr_pkg::mul_prod_t prod
);

	pdr_pkg::mul_prod_t prod_q;

	// One multiply per cycle, product available the cycle after issue.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

// ===== hw/rtl/pdr_cordic.sv =====
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one shift-add micro-rotation per cycle, giving
// Q1.30 cosine and sine of a binary angle. Depends on pdr_pkg for the gain and atan table.
module pdr_cordic #(
	parameter int STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pdr_pkg::cordic_req_t req,
	output logic                done,
	output logic signed [31:0]  cos_val,
	output logic signed [31:0]  sin_val
);

	// Iterations beyond the table length act as the table length.
	localparam int N  = (STEPS > pdr_pkg::ATAN_ENTRIES) ? pdr_pkg::ATAN_ENTRIES : STEPS;
	localparam int CW = (N > 1) ? $clog2(N) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic              flip_q;

	// Second and third quadrant headings are turned by half a turn first.
	logic               flip_in;
	logic [31:0]        ang_rot;
	logic signed [31:0] dx, dy, da;

	assign flip_in = req.angle[31] ^ req.angle[30];
	assign ang_rot = flip_in ? (req.angle ^ 32'h8000_0000) : req.angle;
	assign dx      = y_q >>> cnt_q;
	assign dy      = x_q >>> cnt_q;
	assign da      = pdr_pkg::atan_bam(5'(cnt_q));

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Rotation datapath: rotate toward zero residual angle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= pdr_pkg::CORDIC_GAIN_Q30;
			y_q    <= '0;
			z_q    <= $signed(ang_rot);
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end
		end
	end

	// Undo the half-turn by negating both outputs.
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;
	assign done    = done_q;

endmodule

// ===== hw/rtl/planar_dead_reckoning_step_core.sv =====
`timescale 1ns / 1ps
// Planar dead-reckoning core: sequencer, state registers and accumulator around the
// shared CORDIC and multiplier. Depends on pdr_pkg, pdr_if, pdr_cordic and pdr_mul.

// Each accepted sample word first adds its accelerations to the saturating body
// velocities, then the CORDIC unit produces cosine and sine of the heading held before
// the sample, one micro-rotation per cycle, CORDIC_STEPS of them (at most 30). The
// single 32x32 multiplier then runs eleven back-to-back steps: rotation of the
// velocities, scaling by elapsed time in two partial products per axis, and the heading
// increment. The core takes no new sample until the result word of the last one has
// left the sequencer. The result word sits in an output register, so the next sample
// is accepted while it waits; a second result then waits in the sequencer until the
// first is taken. Positions saturate to 48 bits; the heading is a 32-bit binary angle
// that wraps.
module planar_dead_reckoning_step_core #(
	parameter int CORDIC_STEPS = pdr_pkg::CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pdr_in_if.sink    sample,
	pdr_out_if.source result
);

	typedef enum logic [1:0] {S_IDLE, S_CORDIC, S_MUL, S_DONE} state_t;

	// Multiplier schedule: steps after M_XC use the prior product; M_HD issues none.
	typedef enum logic [3:0] {
		M_XC, M_XS, M_YS, M_YC, M_RXL, M_RXH, M_RYL, M_RYH, M_WR, M_BAM, M_HD
	} mstep_t;

	state_t state_q;
	mstep_t mstep_q;

	pdr_pkg::vel_t   vel_fwd_q, vel_side_q;
	pdr_pkg::pos_t   world_x_q, world_y_q;
	pdr_pkg::angle_t yaw_q;
	logic [15:0]        dt_q;
	logic signed [15:0] wr_q;
	logic               cordic_start_q;

	logic               out_valid_q;
	pdr_pkg::pos_t      out_x_q, out_y_q;
	pdr_pkg::angle_t    out_hd_q;
	logic               out_load;

	logic signed [64:0] acc_q;
	logic signed [42:0] rx_q, ry_q;

	pdr_pkg::cordic_req_t cordic_req;
	logic                 cordic_done;
	logic signed [31:0]   cos_v, sin_v;
	pdr_pkg::mul_op_t     mul_a, mul_b;
	pdr_pkg::mul_prod_t   prod;

	assign cordic_req.start = cordic_start_q;
	assign cordic_req.angle = yaw_q;

	pdr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cordic_req),
		.done    (cordic_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	pdr_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Saturating velocity sums.
	logic signed [32:0] vf_sum, vs_sum;
	pdr_pkg::vel_t      vf_new, vs_new;

	function automatic pdr_pkg::vel_t sat32(input logic signed [32:0] v);
		pdr_pkg::vel_t r;
		if (v[32] != v[31]) begin
			r = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic pdr_pkg::pos_t sat48(input logic signed [49:0] v);
		pdr_pkg::pos_t r;
		if (v > 50'sh0_7FFF_FFFF_FFFF) begin
			r = {1'b0, {47{1'b1}}};
		end else if (v < -50'sh0_8000_0000_0000) begin
			r = {1'b1, 47'd0};
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

	assign vf_sum = {vel_fwd_q[31], vel_fwd_q} + 33'(sample.accel_fwd);
	assign vs_sum = {vel_side_q[31], vel_side_q} + 33'(sample.accel_side);
	assign vf_new = sat32(vf_sum);
	assign vs_new = sat32(vs_sum);

	// Rounding of the accumulator: to Q.16 velocity (drop 22) and to Q.16 metres (drop 16).
	logic signed [64:0] acc_r22, acc_r16, prod_sh21;
	logic signed [42:0] rnd22;
	logic signed [48:0] rnd16;
	logic signed [49:0] pos_sum_x, pos_sum_y;
	logic signed [63:0] hd_sum;
	logic [31:0]        dth;

	assign acc_r22   = acc_q + (65'sd1 <<< 21);
	assign acc_r16   = acc_q + (65'sd1 <<< 15);
	assign rnd22     = acc_r22[64:22];
	assign rnd16     = acc_r16[64:16];
	assign prod_sh21 = {prod[43:0], 21'd0};
	assign pos_sum_x = 50'(world_x_q) + 50'(rnd16);
	assign pos_sum_y = 50'(world_y_q) + 50'(rnd16);
	assign hd_sum    = prod + (64'sd1 <<< 27);
	assign dth       = hd_sum[59:28];

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (mstep_q)
			M_XC: begin
				mul_a = vel_fwd_q;
				mul_b = cos_v;
			end
			M_XS: begin
				mul_a = vel_side_q;
				mul_b = sin_v;
			end
			M_YS: begin
				mul_a = vel_fwd_q;
				mul_b = sin_v;
			end
			M_YC: begin
				mul_a = vel_side_q;
				mul_b = cos_v;
			end
			M_RXL: begin
				mul_a = {11'd0, rx_q[20:0]};
				mul_b = {16'd0, dt_q};
			end
			M_RXH: begin
				mul_a = 32'($signed(rx_q[42:21]));
				mul_b = {16'd0, dt_q};
			end
			M_RYL: begin
				mul_a = {11'd0, ry_q[20:0]};
				mul_b = {16'd0, dt_q};
			end
			M_RYH: begin
				mul_a = 32'($signed(ry_q[42:21]));
				mul_b = {16'd0, dt_q};
			end
			M_WR: begin
				mul_a = 32'(wr_q);
				mul_b = {16'd0, dt_q};
			end
			M_BAM: begin
				mul_a = prod[31:0];
				mul_b = pdr_pkg::BAM_PER_RAD;
			end
			M_HD: begin
				mul_a = '0;
				mul_b = '0;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Accumulator and rotated velocities, fed by the product of the previous step.
	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			unique case (mstep_q)
				M_XS:  acc_q <= 65'(prod);
				M_YS:  acc_q <= acc_q - 65'(prod);
				M_YC: begin
					rx_q  <= rnd22;
					acc_q <= 65'(prod);
				end
				M_RXL: acc_q <= acc_q + 65'(prod);
				M_RXH: begin
					ry_q  <= rnd22;
					acc_q <= 65'(prod);
				end
				M_RYL: acc_q <= acc_q + prod_sh21;
				M_RYH: acc_q <= 65'(prod);
				M_WR:  acc_q <= acc_q + prod_sh21;
				default: acc_q <= acc_q;
			endcase
		end
	end

	// A finished pose moves to the output register once that register is free.
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	// Sequencer, pose state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mstep_q        <= M_XC;
			vel_fwd_q      <= '0;
			vel_side_q     <= '0;
			world_x_q      <= '0;
			world_y_q      <= '0;
			yaw_q          <= '0;
			dt_q           <= '0;
			wr_q           <= '0;
			cordic_start_q <= 1'b0;
			out_valid_q    <= 1'b0;
			out_x_q        <= '0;
			out_y_q        <= '0;
			out_hd_q       <= '0;
		end else begin
			cordic_start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_x_q     <= world_x_q;
				out_y_q     <= world_y_q;
				out_hd_q    <= yaw_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						vel_fwd_q      <= vf_new;
						vel_side_q     <= vs_new;
						dt_q           <= sample.elapsed;
						wr_q           <= sample.yaw_rate;
						cordic_start_q <= 1'b1;
						state_q        <= S_CORDIC;
					end
				end
				S_CORDIC: begin
					if (cordic_done) begin
						mstep_q <= M_XC;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					unique case (mstep_q)
						M_XC:  mstep_q <= M_XS;
						M_XS:  mstep_q <= M_YS;
						M_YS:  mstep_q <= M_YC;
						M_YC:  mstep_q <= M_RXL;
						M_RXL: mstep_q <= M_RXH;
						M_RXH: mstep_q <= M_RYL;
						M_RYL: mstep_q <= M_RYH;
						M_RYH: begin
							world_x_q <= sat48(pos_sum_x);
							mstep_q   <= M_WR;
						end
						M_WR:  mstep_q <= M_BAM;
						M_BAM: begin
							world_y_q <= sat48(pos_sum_y);
							mstep_q   <= M_HD;
						end
						M_HD: begin
							yaw_q   <= yaw_q + dth;
							mstep_q <= M_XC;
							state_q <= S_DONE;
						end
						default: mstep_q <= M_XC;
					endcase
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready   = (state_q == S_IDLE);
	assign result.valid   = out_valid_q;
	assign result.pos_x   = out_x_q;
	assign result.pos_y   = out_y_q;
	assign result.heading = out_hd_q;

endmodule

// ===== hw/rtl/pdr_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the planar dead-reckoning core, bound to its top level.
// Depends on planar_dead_reckoning_step_core and the pdr_if channel interfaces.
module pdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_valid,
	input logic        sample_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [47:0] pos_x,
	input logic [47:0] pos_y,
	input logic [31:0] heading
);

	logic       sample_fire, result_fire;
	logic [1:0] pend_q;

	assign sample_fire = sample_valid && sample_ready;
	assign result_fire = result_valid && result_ready;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, sample_fire} - {1'b0, result_fire};
		end
	end

	// One sample in work plus one result waiting is the most the core can hold.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more words outstanding than the core can hold");

	// No result word without an accepted sample behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result word with no sample outstanding");

	// The core works on one sample at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_fire |=> !sample_ready)
		else $error("sample accepted while the previous one is in work");

	// A stalled result word holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading))
		else $error("stalled result word changed");

endmodule

bind planar_dead_reckoning_step_core pdr_checker u_pdr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.pos_x        (result.pos_x),
	.pos_y        (result.pos_y),
	.heading      (result.heading)
);
